// ===== rtl/fwt_pkg.sv =====
// shared types, codes and helpers of the binary indexed tree block
// no dependencies; imported by the store, the sequencer, the top level and the checker
package fwt_pkg;

  localparam int IDX_W          = 11;
  localparam int POS_W          = IDX_W + 1;
  localparam int DELTA_W        = 32;
  localparam int SUM_W          = 32;
  localparam int CNT_W          = 48;
  localparam int SIZE_W         = 11;
  localparam int SIZE_RESET     = 1024;
  localparam int DEF_TREE_DEPTH = 1024;
  localparam int DEF_ENTRY_BITS = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_QUERY  = 2'd2,
    OP_INSERT = 2'd3
  } fwt_op_e;

  typedef struct packed {
    fwt_op_e                    operation;
    logic [IDX_W-1:0]           index;
    logic signed [DELTA_W-1:0]  delta;
  } fwt_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    prefix_sum;
    logic [CNT_W-1:0]           shift_count;
    logic                       index_error;
  } fwt_out_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } fwt_stat_t;

  function automatic logic [POS_W-1:0] low_bit(logic [POS_W-1:0] v);
    return v & (~v + 1'b1);
  endfunction

endpackage

// ===== rtl/fwt_store.sv =====
// tree entry memory: one write port, one read port, registered read data
// depends on fwt_pkg for the default sizes
module fwt_store
  import fwt_pkg::*;
#(
  parameter int DEPTH      = DEF_TREE_DEPTH,
  parameter int ENTRY_BITS = DEF_ENTRY_BITS,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [ENTRY_BITS-1:0] rd_data_o,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [ENTRY_BITS-1:0] wr_data_i
);

  logic [ENTRY_BITS-1:0] mem_q [DEPTH];
  logic [ENTRY_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/fwt_ctrl.sv =====
// walk sequencer: clearing sweep, downward prefix walk, counter update, upward add walk
// depends on fwt_pkg; drives the ports of fwt_store
module fwt_ctrl
  import fwt_pkg::*;
#(
  parameter int DEPTH      = DEF_TREE_DEPTH,
  parameter int ENTRY_BITS = DEF_ENTRY_BITS,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  fwt_in_t               item_i,
  input  logic [SIZE_W-1:0]     size_i,
  input  logic                  res_take_i,
  output fwt_stat_t             stat_o,
  output fwt_out_t              res_o,
  output logic                  rd_en_o,
  output logic [AW-1:0]         rd_addr_o,
  input  logic [ENTRY_BITS-1:0] rd_data_i,
  output logic                  wr_en_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [ENTRY_BITS-1:0] wr_data_o
);

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QRD   = 3'd2;
  localparam logic [2:0] ST_QACC  = 3'd3;
  localparam logic [2:0] ST_CNT   = 3'd4;
  localparam logic [2:0] ST_URD   = 3'd5;
  localparam logic [2:0] ST_UWR   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  logic [2:0]            state_q, state_d;
  fwt_op_e               op_q, op_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [ENTRY_BITS-1:0] amt_q, amt_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [ENTRY_BITS-1:0] acc_q, acc_d;
  logic [AW-1:0]         sweep_q, sweep_d;
  logic [CNT_W-1:0]      items_q, items_d;
  logic [CNT_W-1:0]      shifts_q, shifts_d;
  logic                  clr_item_q, clr_item_d;
  fwt_out_t              res_q, res_d;

  logic                  idx_ok;
  logic [ENTRY_BITS-1:0] sum_next;
  logic [POS_W-1:0]      pos_down;
  logic [POS_W-1:0]      pos_up;

  assign idx_ok   = (item_i.index != '0) && (item_i.index <= size_i);
  assign sum_next = acc_q + rd_data_i;
  assign pos_down = pos_q - low_bit(pos_q);
  assign pos_up   = pos_q + low_bit(pos_q);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    amt_d      = amt_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    sweep_d    = sweep_q;
    items_d    = items_q;
    shifts_d   = shifts_q;
    clr_item_d = clr_item_q;
    res_d      = res_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = AW'(pos_q - 1'b1);
    wr_en_o    = 1'b0;
    wr_addr_o  = AW'(pos_q - 1'b1);
    wr_data_o  = rd_data_i + amt_q;

    case (state_q)
      ST_SWEEP: begin
        wr_en_o   = 1'b1;
        wr_addr_o = sweep_q;
        wr_data_o = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == LastAddr) begin
          if (clr_item_q) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d  = item_i.operation;
          idx_d = item_i.index;
          pos_d = {1'b0, item_i.index};
          acc_d = '0;
          if (item_i.operation == OP_INSERT) begin
            amt_d = ENTRY_BITS'(1);
          end else begin
            amt_d = ENTRY_BITS'(item_i.delta);
          end
          if (item_i.operation == OP_CLEAR) begin
            items_d    = '0;
            shifts_d   = '0;
            sweep_d    = '0;
            clr_item_d = 1'b1;
            state_d    = ST_SWEEP;
          end else if (!idx_ok) begin
            res_d.prefix_sum  = '0;
            res_d.shift_count = shifts_q;
            res_d.index_error = 1'b1;
            state_d           = ST_DONE;
          end else begin
            state_d = ST_QRD;
          end
        end
      end
      ST_QRD: begin
        rd_en_o = 1'b1;
        state_d = ST_QACC;
      end
      ST_QACC: begin
        acc_d = sum_next;
        pos_d = pos_down;
        if (pos_down != '0) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(pos_down - 1'b1);
        end else begin
          res_d.prefix_sum  = SUM_W'(sum_next);
          res_d.shift_count = shifts_q;
          res_d.index_error = 1'b0;
          pos_d             = {1'b0, idx_q};
          case (op_q)
            OP_ADD:    state_d = ST_URD;
            OP_INSERT: state_d = ST_CNT;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CNT: begin
        // earlier inserts minus those not greater gives the new inversions
        shifts_d          = shifts_q + (items_q - CNT_W'(acc_q));
        items_d           = items_q + 1'b1;
        res_d.shift_count = shifts_d;
        state_d           = ST_URD;
      end
      ST_URD: begin
        rd_en_o = 1'b1;
        state_d = ST_UWR;
      end
      ST_UWR: begin
        // write back this entry while fetching the next, always a higher address
        wr_en_o = 1'b1;
        pos_d   = pos_up;
        if (pos_up <= {1'b0, size_i}) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(pos_up - 1'b1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d    = ST_IDLE;
          clr_item_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      sweep_q    <= '0;
      clr_item_q <= 1'b0;
      items_q    <= '0;
      shifts_q   <= '0;
    end else begin
      state_q    <= state_d;
      sweep_q    <= sweep_d;
      clr_item_q <= clr_item_d;
      items_q    <= items_d;
      shifts_q   <= shifts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    idx_q <= idx_d;
    amt_q <= amt_d;
    pos_q <= pos_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign stat_o.idle      = (state_q == ST_IDLE);
  assign stat_o.res_valid = (state_q == ST_DONE);
  assign res_o            = res_q;

endmodule

// ===== rtl/fenwick_tree_prefix_sum.sv =====
// steps to out_valid_o: a query reads each entry of the downward prefix walk, an add then reads
// and writes back each entry of the upward walk, count_insert updates the counter between the walks,
// a bad index goes straight to the result; one item at a time, the next accepted once the result
// is registered, set by the walks over the single read/write port pair of the tree memory
// reset and clear: a sweep over all TREE_DEPTH entries zeroes the memory, input stalled meanwhile
// depends on fwt_pkg, fwt_ctrl and fwt_store
module fenwick_tree_prefix_sum
  import fwt_pkg::*;
#(
  parameter int TREE_DEPTH = DEF_TREE_DEPTH,
  parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fwt_in_t           in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fwt_out_t          out_item_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(TREE_DEPTH);
  localparam logic [SIZE_W-1:0] SizeMax =
    (TREE_DEPTH > 2047) ? SIZE_W'(2047) : SIZE_W'(TREE_DEPTH);
  localparam logic [SIZE_W-1:0] SizeInit =
    (SIZE_RESET > TREE_DEPTH) ? SizeMax : SIZE_W'(SIZE_RESET);

  logic [SIZE_W-1:0]     size_q, size_d;
  logic                  out_valid_q, out_valid_d;
  fwt_out_t              out_item_q;
  fwt_stat_t             stat;
  fwt_out_t              res;
  logic                  res_take;
  logic                  start;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;

  // size register, clamped to 1..TREE_DEPTH and to at most 2047
  always_comb begin
    size_d = size_q;
    if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        size_d = SIZE_W'(1);
      end else if (32'(cfg_data_i) > TREE_DEPTH) begin
        size_d = SizeMax;
      end else begin
        size_d = cfg_data_i;
      end
    end
  end

  assign in_stall_o = !stat.idle;
  assign start      = in_valid_i && !in_stall_o;
  assign res_take   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (stat.res_valid && res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SizeInit;
      out_valid_q <= 1'b0;
    end else begin
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_valid && res_take) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  fwt_ctrl #(
    .DEPTH      (TREE_DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_item_i),
    .size_i     (size_q),
    .res_take_i (res_take),
    .stat_o     (stat),
    .res_o      (res),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  fwt_store #(
    .DEPTH      (TREE_DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data)
  );

endmodule

// ===== rtl/fwt_checker.sv =====
// port-level checks of the binary indexed tree block, bound to the top level
// depends on fwt_pkg and fenwick_tree_prefix_sum
module fwt_checker
  import fwt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fwt_out_t          out_item_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // a rejected index never reports a sum
  a_err_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.index_error |-> out_item_o.prefix_sum == '0)
    else $error("index error with nonzero prefix sum");

  // one item at a time: a transfer in closes the input
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer right after the first");

  // the clearing sweep runs after reset with nothing pending at the output
  a_reset_sweep: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input open or result pending right after reset");

endmodule

bind fenwick_tree_prefix_sum fwt_checker u_fwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== verif/tb_top.sv =====
// self-checking testbench of the binary indexed tree prefix-sum block
// predicts every result in a scoreboard class and drives both handshakes at random pace outside the quiet phases
// depends on fwt_pkg and fenwick_tree_prefix_sum
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fwt_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 42;

  class prefix_sum_tracker;
    logic [SUM_W-1:0] entries [1:DEF_TREE_DEPTH];
    logic [CNT_W-1:0] inserted;
    logic [CNT_W-1:0] shifts;
    int unsigned      size;
    fwt_out_t         pending_results [$];
    int               errors;

    function new();
      clear_all();
      size   = SIZE_RESET;
      errors = 0;
    endfunction

    function void clear_all();
      foreach (entries[i]) entries[i] = '0;
      inserted = '0;
      shifts   = '0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] value);
      if (value == 0) size = 1;
      else if (value > DEF_TREE_DEPTH) size = DEF_TREE_DEPTH;
      else size = value;
    endfunction

    function logic [SUM_W-1:0] walk_down(int unsigned pos);
      logic [SUM_W-1:0] acc;
      acc = '0;
      while (pos > 0) begin
        acc = acc + entries[pos];
        pos = pos - (pos & (~pos + 1));
      end
      return acc;
    endfunction

    function void walk_up(int unsigned pos, logic [SUM_W-1:0] amount);
      while (pos != 0 && pos <= size) begin
        entries[pos] = entries[pos] + amount;
        pos = pos + (pos & (~pos + 1));
      end
    endfunction

    function void note_item(fwt_in_t it);
      fwt_out_t         res;
      logic [SUM_W-1:0] sum;
      int unsigned      pos;
      res = '0;
      pos = it.index;
      if (it.operation == OP_CLEAR) begin
        clear_all();
      end else if (pos == 0 || pos > size) begin
        res.index_error = 1'b1;
      end else begin
        // the sum is taken before this item touches the store
        sum = walk_down(pos);
        res.prefix_sum = sum;
        if (it.operation == OP_ADD) begin
          walk_up(pos, it.delta);
        end else if (it.operation == OP_INSERT) begin
          // earlier items greater than this value
          shifts   = shifts + (inserted - {{(CNT_W-SUM_W){1'b0}}, sum});
          inserted = inserted + 1'b1;
          walk_up(pos, 1);
        end
      end
      res.shift_count = shifts;
      pending_results.push_back(res);
    endfunction

    function void check_result(fwt_out_t got);
      fwt_out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing pending: sum %0d shifts %0d err %0b",
                   got.prefix_sum, got.shift_count, got.index_error);
        return;
      end
      want = pending_results.pop_front();
      if (got.prefix_sum != want.prefix_sum || got.shift_count != want.shift_count ||
          got.index_error != want.index_error) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: sum exp %0d got %0d, shifts exp %0d got %0d, err exp %0b got %0b",
                   want.prefix_sum, got.prefix_sum, want.shift_count, got.shift_count,
                   want.index_error, got.index_error);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall_o;
  fwt_in_t           in_item    = '0;
  logic              out_valid_o;
  logic              out_stall  = 1'b0;
  fwt_out_t          out_item_o;
  logic              cfg_we     = 1'b0;
  logic [SIZE_W-1:0] cfg_data   = '0;
  bit                quiet      = 1'b0;
  int                cycles     = 0;

  prefix_sum_tracker tracker = new();

  fenwick_tree_prefix_sum u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) tracker.note_item(in_item);
      if (out_valid_o && !out_stall) tracker.check_result(out_item_o);
    end
  end

  // result side: random stall before each transfer
  initial begin
    int n;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        @(negedge clk_i) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic fwt_in_t mk(fwt_op_e op, int unsigned idx, logic [DELTA_W-1:0] d);
    fwt_in_t it;
    it.operation = op;
    it.index     = idx;
    it.delta     = d;
    return it;
  endfunction

  function automatic fwt_in_t make_item(int unsigned size);
    fwt_in_t     it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) it.operation = OP_CLEAR;
    else if (r < 40) it.operation = OP_ADD;
    else if (r < 65) it.operation = OP_QUERY;
    else it.operation = OP_INSERT;
    r = $urandom_range(0, 19);
    if (r == 0) it.index = 0;
    else if (r == 1) it.index = $urandom_range(size + 1, 2047);
    else if (r == 2) it.index = size;
    else it.index = $urandom_range(1, size);
    r = $urandom_range(0, 9);
    if (r == 0) it.delta = 32'h8000_0000;
    else if (r == 1) it.delta = 32'h7fff_ffff;
    else if (r < 5) it.delta = $signed($urandom_range(0, 200)) - 100;
    else it.delta = $urandom;
    return it;
  endfunction

  task automatic send_item(fwt_in_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) @(negedge clk_i) in_valid <= 1'b0;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // returns at a falling edge with every result in and the block ready
  task automatic wait_drain();
    @(negedge clk_i) in_valid <= 1'b0;
    while (tracker.outstanding() != 0 || in_stall_o) @(negedge clk_i);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    wait_drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i) cfg_we <= 1'b0;
    tracker.set_size(value);
  endtask

  task automatic run_directed();
    send_item(mk(OP_QUERY, 1, 0));
    send_item(mk(OP_ADD, 1, 32'h7fff_ffff));
    send_item(mk(OP_ADD, 1024, 32'h8000_0000));
    send_item(mk(OP_ADD, 1, 1));
    send_item(mk(OP_QUERY, 1024, 0));
    send_item(mk(OP_QUERY, 0, 0));
    send_item(mk(OP_ADD, 0, 5));
    send_item(mk(OP_INSERT, 0, 0));
    send_item(mk(OP_ADD, 2047, 32'hffff_ffff));
    send_item(mk(OP_QUERY, 1025, 0));
    send_item(mk(OP_INSERT, 5, 0));
    send_item(mk(OP_INSERT, 3, 0));
    send_item(mk(OP_INSERT, 1024, 0));
    send_item(mk(OP_INSERT, 1, 0));
    send_item(mk(OP_INSERT, 5, 0));
    send_item(mk(OP_QUERY, 5, 0));
    // clear ignores its index and delta
    send_item(mk(OP_CLEAR, 2047, 32'hffff_ffff));
    send_item(mk(OP_QUERY, 1024, 0));
    send_item(mk(OP_ADD, 512, 32'hffff_ffff));
    send_item(mk(OP_INSERT, 700, 32'h1234_5678));
    send_item(mk(OP_QUERY, 1023, 0));
    send_item(mk(OP_ADD, 1023, 32'h5555_aaaa));
    send_item(mk(OP_INSERT, 2, 0));
    send_item(mk(OP_QUERY, 1024, 0));
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [PHASES];
    sizes = '{11'd1024, 11'd0, 11'd2, 11'd2047, 11'd1, 11'd1023, 11'd0, 11'd64, 11'd1024};
    sizes[6] = $urandom_range(3, 1000);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p % 3 == 2);
      write_size(sizes[p]);
      if (p == 0) run_directed();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) wait_drain();
        send_item(make_item(tracker.size));
      end
    end
    @(negedge clk_i) in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
